[rtl/assert_macros.svh]
// Assertion macros used by the checker file of this block.
// Depends on nothing; included by the checker only.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define CHK_IMPL(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define CHK_NEXT(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("check failed");

`endif

[rtl/lwc_pkg.sv]
// Types, constants and step functions of the line window clipper.
// Depends on nothing; imported by line_window_clipper.
package lwc_pkg;

  localparam int CW        = 16;          // coordinate width, Q12.4
  localparam int RW        = CW - 1;      // window register width
  localparam int PF        = 16;          // parameter fraction bits
  localparam int DIV_BITS  = 4;           // quotient bits per divider stage
  localparam int DIV_STAGES = PF / DIV_BITS;
  localparam int MW        = PF + CW + 3; // product width
  localparam int NEDGE     = 4;

  localparam logic [PF:0] PARAM_ONE = {1'b1, {PF{1'b0}}};

  // Register indexes
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic signed [CW-1:0] start_x;
    logic signed [CW-1:0] start_y;
    logic signed [CW-1:0] end_x;
    logic signed [CW-1:0] end_y;
  } seg_t;

  typedef struct packed {
    logic                 visible;
    logic signed [CW-1:0] clip_start_x;
    logic signed [CW-1:0] clip_start_y;
    logic signed [CW-1:0] clip_end_x;
    logic signed [CW-1:0] clip_end_y;
  } clip_t;

  // Segment geometry carried down the pipeline
  typedef struct packed {
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic signed [CW-1:0] ex;
    logic signed [CW-1:0] ey;
    logic signed [CW:0]   dx;
    logic signed [CW:0]   dy;
  } geo_t;

  // One edge test in flight through the divider
  typedef struct packed {
    logic [CW:0]   ap;
    logic [CW:0]   rem;
    logic [PF-1:0] quo;
    logic          pzero;
    logic          qneg;
    logic          pneg;
    logic          differ;
    logic          sat;
  } edge_t;

  typedef edge_t [NEDGE-1:0] edges_t;

  // Restoring division, DIV_BITS quotient bits; rem stays below ap.
  function automatic edge_t div_step(edge_t e);
    edge_t       o;
    logic [CW+1:0] r2;
    o = e;
    for (int k = 0; k < DIV_BITS; k++) begin
      r2 = {o.rem, 1'b0};
      if (r2 >= {1'b0, o.ap}) begin
        r2    = r2 - {1'b0, o.ap};
        o.quo = {o.quo[PF-2:0], 1'b1};
      end else begin
        o.quo = {o.quo[PF-2:0], 1'b0};
      end
      o.rem = r2[CW:0];
    end
    return o;
  endfunction

  // Ratio of one edge, Q1.PF in [0,1]
  function automatic logic [PF:0] edge_ratio(edge_t e);
    logic [PF:0] r;
    if (e.differ)   r = '0;
    else if (e.sat) r = PARAM_ONE;
    else            r = {1'b0, e.quo};
    return r;
  endfunction

endpackage

[rtl/line_window_clipper.sv]
// Liang-Barsky line clipper, top level with config port and pipeline.
// Depends on lwc_pkg.
//
// Clips one segment against [0,window_width]x[0,window_height] per item.
// One item enters per cycle while seg_stall is low; the stages are edge setup, four
// divider stages of four quotient bits each, entry/exit combine, the
// four point multiplies, and the final round and add into the output
// register. Stalls back up stage by stage, so empty stages still fill.
module line_window_clipper
  import lwc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        seg_valid,
  output logic        seg_stall,
  input  seg_t        seg,
  output logic        clip_valid,
  input  logic        clip_stall,
  output clip_t       clip
);

  localparam int NST = DIV_STAGES + 4; // prep, divider, combine, mul, out

  logic [RW-1:0] window_width;
  logic [RW-1:0] window_height;

  // Configuration registers
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      window_width  <= RW'(4800);
      window_height <= RW'(2400);
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_WIDTH:  window_width  <= pwdata[RW-1:0];
        REG_HEIGHT: window_height <= pwdata[RW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_WIDTH:  prdata = 32'(window_width);
      REG_HEIGHT: prdata = 32'(window_height);
      default:    prdata = '0;
    endcase
  end

  // Stage valid bits and per-stage advance
  logic [NST-1:0] vld;
  logic [NST-1:0] en;

  always_comb begin
    en[NST-1] = !vld[NST-1] || !clip_stall;
    for (int i = NST - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign seg_stall  = !en[0];
  assign clip_valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= seg_valid;
      for (int i = 1; i < NST; i++) begin
        if (en[i]) vld[i] <= vld[i-1];
      end
    end
  end

  // Edge setup: deltas, distances and divider start values
  geo_t   geo_in;
  edges_t edg_in;

  always_comb begin
    logic signed [CW+1:0] p [NEDGE];
    logic signed [CW+1:0] q [NEDGE];
    logic [CW+1:0]        ap;
    logic [CW+1:0]        aq;
    geo_in.sx = seg.start_x;
    geo_in.sy = seg.start_y;
    geo_in.ex = seg.end_x;
    geo_in.ey = seg.end_y;
    geo_in.dx = (CW+1)'(seg.end_x) - (CW+1)'(seg.start_x);
    geo_in.dy = (CW+1)'(seg.end_y) - (CW+1)'(seg.start_y);
    p[0] = -(CW+2)'(geo_in.dx);
    p[1] =  (CW+2)'(geo_in.dx);
    p[2] = -(CW+2)'(geo_in.dy);
    p[3] =  (CW+2)'(geo_in.dy);
    q[0] = (CW+2)'(seg.start_x);
    q[1] = $signed((CW+2)'(window_width)) - (CW+2)'(seg.start_x);
    q[2] = (CW+2)'(seg.start_y);
    q[3] = $signed((CW+2)'(window_height)) - (CW+2)'(seg.start_y);
    for (int i = 0; i < NEDGE; i++) begin
      ap = p[i][CW+1] ? -p[i] : p[i];
      aq = q[i][CW+1] ? -q[i] : q[i];
      edg_in[i].ap     = ap[CW:0];
      edg_in[i].pzero  = (p[i] == '0);
      edg_in[i].qneg   = q[i][CW+1];
      edg_in[i].pneg   = p[i][CW+1];
      edg_in[i].differ = (q[i] != '0) && (q[i][CW+1] != p[i][CW+1]);
      edg_in[i].sat    = (aq >= ap);
      edg_in[i].rem    = (aq >= ap) ? '0 : aq[CW:0];
      edg_in[i].quo    = '0;
    end
  end

  // Setup and divider stages
  geo_t   geo [DIV_STAGES+1];
  edges_t edg [DIV_STAGES+1];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      geo[0] <= geo_in;
      edg[0] <= edg_in;
    end
    for (int s = 1; s <= DIV_STAGES; s++) begin
      if (en[s]) begin
        geo[s] <= geo[s-1];
        for (int i = 0; i < NEDGE; i++) begin
          edg[s][i] <= div_step(edg[s-1][i]);
        end
      end
    end
  end

  // Combine edges into entry and exit parameters
  localparam int SC = DIV_STAGES + 1;
  geo_t        geo_c;
  logic [PF:0] ta_c;
  logic [PF:0] tb_c;
  logic        vis_c;

  always_comb begin
    logic [PF:0] ta;
    logic [PF:0] tb;
    logic [PF:0] r;
    ta = '0;
    tb = PARAM_ONE;
    for (int i = 0; i < NEDGE; i++) begin
      r = edge_ratio(edg[DIV_STAGES][i]);
      if (edg[DIV_STAGES][i].pzero) begin
        if (edg[DIV_STAGES][i].qneg) ta = PARAM_ONE;
      end else if (edg[DIV_STAGES][i].pneg) begin
        if (r > ta) ta = r;
      end else begin
        if (r < tb) tb = r;
      end
    end
    ta_c = ta;
    tb_c = tb;
  end

  always_ff @(posedge clk) begin
    if (en[SC]) begin
      geo_c <= geo[DIV_STAGES];
      vis_c <= (tb_c > ta_c);
    end
  end

  logic [PF:0] ta_r;
  logic [PF:0] tb_r;
  always_ff @(posedge clk) begin
    if (en[SC]) begin
      ta_r <= ta_c;
      tb_r <= tb_c;
    end
  end

  // Point multiplies t*d
  geo_t                 geo_m;
  logic                 vis_m;
  logic signed [MW-1:0] prod [NEDGE];

  always_ff @(posedge clk) begin
    if (en[SC+1]) begin
      geo_m   <= geo_c;
      vis_m   <= vis_c;
      prod[0] <= MW'($signed({1'b0, ta_r}) * geo_c.dx);
      prod[1] <= MW'($signed({1'b0, ta_r}) * geo_c.dy);
      prod[2] <= MW'($signed({1'b0, tb_r}) * geo_c.dx);
      prod[3] <= MW'($signed({1'b0, tb_r}) * geo_c.dy);
    end
  end

  // Round half up, add to start, select against rejection
  logic signed [CW-1:0] mv [NEDGE];
  always_comb begin
    logic signed [MW:0] v;
    for (int i = 0; i < NEDGE; i++) begin
      v     = (MW+1)'(prod[i]) + (MW+1)'(PARAM_ONE >> 1);
      mv[i] = CW'(v >>> PF) + ((i % 2 == 0) ? geo_m.sx : geo_m.sy);
    end
  end

  always_ff @(posedge clk) begin
    if (en[NST-1]) begin
      clip.visible <= vis_m;
      if (vis_m) begin
        clip.clip_start_x <= mv[0];
        clip.clip_start_y <= mv[1];
        clip.clip_end_x   <= mv[2];
        clip.clip_end_y   <= mv[3];
      end else begin
        clip.clip_start_x <= geo_m.sx;
        clip.clip_start_y <= geo_m.sy;
        clip.clip_end_x   <= geo_m.ex;
        clip.clip_end_y   <= geo_m.ey;
      end
    end
  end

endmodule

[rtl/lwc_checker.sv]
// Port-level checks of the line window clipper, bound to its top level.
// Depends on lwc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lwc_checker
  import lwc_pkg::*;
(
  input logic  clk,
  input logic  rst,
  input logic  seg_stall,
  input logic  clip_valid,
  input logic  clip_stall,
  input clip_t clip
);

  // Input stalls only when the whole pipe is full and the output is held
  `CHK_IMPL(a_stall_source, clk, rst, seg_stall, clip_valid && clip_stall)
  // Reset empties the pipe
  `CHK_NEXT(a_reset_empty, clk, 1'b0, rst, !clip_valid)
  // A held result stays offered
  `CHK_NEXT(a_hold_valid, clk, rst, clip_valid && clip_stall, clip_valid)
  // A held result does not change
  `CHK_NEXT(a_hold_item, clk, rst, clip_valid && clip_stall, $stable(clip))

endmodule

bind line_window_clipper lwc_checker u_lwc_checker (
  .clk        (clk),
  .rst        (rst),
  .seg_stall  (seg_stall),
  .clip_valid (clip_valid),
  .clip_stall (clip_stall),
  .clip       (clip)
);

[dv/tb_top.sv]
// Self-checking testbench for line_window_clipper: directed table, then random segments.
// Depends on lwc_pkg and the line_window_clipper RTL; results are checked by a built-in predictor.
module tb_top
  import lwc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] ADDR_WIDTH  = 3'd0;
  localparam logic [2:0] ADDR_HEIGHT = 3'd4;
  localparam int P_ONE = 65536;
  localparam int RB = $bits(clip_t);

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        seg_valid = 1'b0;
  logic        seg_stall;
  seg_t        seg = '0;
  logic        clip_valid;
  logic        clip_stall = 1'b0;
  clip_t       clip;

  int unsigned win_w = 4800, win_h = 2400;
  clip_t       clip_q[$];
  int          errors = 0;
  int          hold_cycles = 0;   // long receiver hold-off request

  line_window_clipper u_dut (.*);

  always #1 clk = ~clk;

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

  task automatic report(input string what, input logic [RB-1:0] got,
                        input logic [RB-1:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // One edge test: raises entry (p<0, or p=0 with q<0) or lowers exit (p>0)
  function automatic void clip_edge(input longint p, input longint q,
                                    inout longint ta, inout longint tb);
    longint r;
    longint ap;
    ap = (p < 0) ? -p : p;
    if (p == 0) begin
      if (q < 0) ta = P_ONE;
      return;
    end
    if (q != 0 && ((q < 0) != (p < 0))) r = 0;
    else begin
      r = (((q < 0) ? -q : q) << 16) / ap;
      if (r > P_ONE) r = P_ONE;
    end
    if (p < 0) begin
      if (r > ta) ta = r;
    end else if (r < tb) tb = r;
  endfunction

  // start + round(t*d/2^16), halves toward plus infinity
  function automatic logic [15:0] move_pt(input longint s, input longint t, input longint d);
    longint v;
    v = t * d + P_ONE / 2;
    return 16'(s + (v >>> 16));
  endfunction

  function automatic clip_t clip_segment(input seg_t s);
    clip_t  c;
    longint sx, sy, ex, ey, dx, dy, ta, tb;
    sx = s.start_x; sy = s.start_y; ex = s.end_x; ey = s.end_y;
    dx = ex - sx; dy = ey - sy; ta = 0; tb = P_ONE;
    clip_edge(-dx, sx, ta, tb);
    clip_edge(dx, longint'(win_w) - sx, ta, tb);
    clip_edge(-dy, sy, ta, tb);
    clip_edge(dy, longint'(win_h) - sy, ta, tb);
    if (tb <= ta) begin
      c = {1'b0, s.start_x, s.start_y, s.end_x, s.end_y};
    end else begin
      c.visible      = 1'b1;
      c.clip_start_x = move_pt(sx, ta, dx);
      c.clip_start_y = move_pt(sy, ta, dy);
      c.clip_end_x   = move_pt(sx, tb, dx);
      c.clip_end_y   = move_pt(sy, tb, dy);
    end
    return c;
  endfunction

  // Register write: setup then access cycle
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == ADDR_WIDTH) win_w = data[14:0];
    else win_h = data[14:0];
  endtask

  // Stop offering, then wait for every expected result
  task automatic drain();
    seg_valid <= 1'b0;
    while (clip_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // Offer one segment, hold until accepted; valid stays up for a back-to-back item
  task automatic send_seg(input seg_t s, input int gap);
    if (gap > 0) begin
      seg_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    seg <= s; seg_valid <= 1'b1;
    do @(posedge clk); while (seg_stall);
    clip_q = {clip_q, clip_segment(s)};
  endtask

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 5000));
      2: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      default: return 16'(int'($urandom_range(0, 6000)) - 600);
    endcase
  endfunction

  // Receiver: draws a wait per item, plus a long hold-off when requested
  initial begin
    int wait_n;
    forever begin
      if (hold_cycles > 0) begin
        clip_stall <= 1'b1;
        hold_cycles--;
        @(posedge clk);
      end else begin
        wait_n = $urandom_range(0, 10);
        if (wait_n > 0) begin
          clip_stall <= 1'b1;
          repeat (wait_n) @(posedge clk);
        end
        clip_stall <= 1'b0;
        do @(posedge clk); while (!(clip_valid && !rst) && hold_cycles == 0);
      end
    end
  end

  // Result checker
  always @(posedge clk) begin
    if (!rst && clip_valid && !clip_stall) begin
      if (clip_q.size() == 0) report("unexpected item", clip, '0);
      else begin
        clip_t w;
        w = clip_q.pop_front();
        if (clip.visible !== w.visible)
          report("visible", RB'(clip.visible), RB'(w.visible));
        if (clip.clip_start_x !== w.clip_start_x)
          report("clip_start_x", RB'(clip.clip_start_x), RB'(w.clip_start_x));
        if (clip.clip_start_y !== w.clip_start_y)
          report("clip_start_y", RB'(clip.clip_start_y), RB'(w.clip_start_y));
        if (clip.clip_end_x !== w.clip_end_x)
          report("clip_end_x", RB'(clip.clip_end_x), RB'(w.clip_end_x));
        if (clip.clip_end_y !== w.clip_end_y)
          report("clip_end_y", RB'(clip.clip_end_y), RB'(w.clip_end_y));
      end
    end
  end

  typedef struct {
    seg_t  s;
    bit    known;
    clip_t want;
  } dir_row_t;

  dir_row_t dir_rows[] = '{
    '{'{16'sd100, 16'sd100, 16'sd200, 16'sd200}, 1, '{1'b1, 16'sd100, 16'sd100, 16'sd200, 16'sd200}},
    '{'{-16'sd10, -16'sd10, -16'sd5, -16'sd5}, 1, '{1'b0, -16'sd10, -16'sd10, -16'sd5, -16'sd5}},
    '{'{16'sd100, -16'sd1, 16'sd200, -16'sd1}, 1, '{1'b0, 16'sd100, -16'sd1, 16'sd200, -16'sd1}},
    '{'{-16'sd1, 16'sd100, -16'sd1, 16'sd200}, 1, '{1'b0, -16'sd1, 16'sd100, -16'sd1, 16'sd200}},
    '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1, '{1'b1, 16'sd0, 16'sd0, 16'sd0, 16'sd0}},
    '{'{16'sd0, 16'sd0, 16'sd4800, 16'sd2400}, 1, '{1'b1, 16'sd0, 16'sd0, 16'sd4800, 16'sd2400}},
    '{'{-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767}, 0, '0},
    '{'{16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768}, 0, '0},
    '{'{-16'sd32768, 16'sd1200, 16'sd32767, 16'sd1200}, 0, '0},
    '{'{16'sd2400, -16'sd32768, 16'sd2400, 16'sd32767}, 0, '0},
    '{'{-16'sd100, 16'sd2500, 16'sd200, 16'sd2200}, 0, '0},
    '{'{16'sd4800, 16'sd0, 16'sd5000, 16'sd100}, 0, '0},
    '{'{16'sd5000, 16'sd1000, 16'sd4000, 16'sd1100}, 0, '0},
    '{'{16'sd4801, 16'sd2401, 16'sd4801, 16'sd2401}, 1, '{1'b0, 16'sd4801, 16'sd2401, 16'sd4801, 16'sd2401}},
    '{'{-16'sd1, 16'sd1, 16'sd1, -16'sd1}, 0, '0},
    '{'{-16'sd3, 16'sd5, 16'sd4, 16'sd7}, 0, '0}
  };

  initial begin
    seg_t s;
    int   n;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows at reset window
    foreach (dir_rows[i]) begin
      send_seg(dir_rows[i].s, $urandom_range(0, 2));
      if (dir_rows[i].known && clip_q[$] !== dir_rows[i].want)
        report("table row", clip_q[$], dir_rows[i].want);
    end
    drain();

    // Zero-size window, then the widest one
    write_reg(ADDR_WIDTH, 32'h0);
    write_reg(ADDR_HEIGHT, 32'h0);
    for (int i = 0; i < 6; i++) send_seg(dir_rows[i].s, 0);
    drain();
    write_reg(ADDR_WIDTH, 32'hffff_ffff);
    write_reg(ADDR_HEIGHT, 32'h7fff);
    for (int i = 6; i < 12; i++) send_seg(dir_rows[i].s, 0);
    drain();

    // Random phases over several window settings
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(ADDR_WIDTH, (ph == 3) ? 32'h7fff : $urandom_range(0, 6000));
      write_reg(ADDR_HEIGHT, (ph == 3) ? 32'h0 : $urandom_range(0, 6000));
      if (ph == 1) hold_cycles = 60;
      n = 0;
      while (n < 200) begin
        s = {rand_coord(), rand_coord(), rand_coord(), rand_coord()};
        send_seg(s, ($urandom_range(0, 3) == 0) ? 0 : (n % 40 < 15 ? 0 : $urandom_range(0, 10)));
        n++;
        if (n == 100 && ph == 2) begin
          seg_valid <= 1'b0;
          @(posedge clk);
          while (clip_q.size() != 0) @(posedge clk);
        end
      end
      drain();
    end

    fork
      begin
        int lim;
        lim = 0;
        while (clip_q.size() != 0 && lim < 5000) begin
          @(posedge clk);
          lim++;
        end
      end
    join
    repeat (20) @(posedge clk);
    if (errors == 0 && clip_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/lwc_pkg.sv
rtl/line_window_clipper.sv
rtl/lwc_checker.sv
dv/tb_top.sv
